// ----- hdl/per_channel_running_stats_top_macros.svh -----
// Assertion macros shared by the per-channel running statistics block.
`ifndef PER_CHANNEL_RUNNING_STATS_TOP_MACROS_SVH
`define PER_CHANNEL_RUNNING_STATS_TOP_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define PCRS_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Checks that a condition implies another in the following cycle.
`define PCRS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- hdl/pcrs_pkg.sv -----
// Types and constants shared by the per-channel running statistics block.
package pcrs_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int SAMPLE_BITS  = 16;
    localparam int COUNT_BITS   = 24;
    localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
    localparam int CFG_BITS     = 3;
    localparam int CH_OUT_BITS  = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_LIMIT    = (1 << CFG_BITS) - 1;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(4);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last_in_frame;
    } t_sample;

    typedef struct packed {
        logic [CH_OUT_BITS-1:0] channel;
        logic [SAMPLE_BITS-1:0] mean;
        logic [SAMPLE_BITS-1:0] minimum;
        logic [SAMPLE_BITS-1:0] maximum;
        logic [COUNT_BITS-1:0]  sample_count;
        logic                   frame_done;
        logic                   overflow;
    } t_result;

    typedef struct packed {
        logic [CFG_BITS-1:0]    channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } t_work;

    typedef struct packed {
        logic                   start;
        logic [SUM_BITS-1:0]    dividend;
        logic [COUNT_BITS-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_OUTPUT
    } t_back_state;

endpackage

// ----- hdl/pcrs_front.sv -----
// Front end: accepts samples, holds the channel count and assigns each sample its channel.
module pcrs_front import pcrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_sample             i_data,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output logic                o_push,
    output t_work               o_item,
    input  logic                i_full
);

    localparam int DEPTH = (MAX_CHANNELS < CFG_LIMIT) ? MAX_CHANNELS : CFG_LIMIT;
    localparam int CH_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CFG_BITS-1:0] DEPTH_C = CFG_BITS'(DEPTH);

    logic [CFG_BITS-1:0] r_cfg;
    logic [CH_W-1:0]     r_pos;
    logic [CH_W-1:0]     n_pos;
    logic [CFG_BITS-1:0] active;
    logic [CFG_BITS-1:0] pos_ext;
    logic [CFG_BITS-1:0] ch;
    logic [CFG_BITS-1:0] ch_inc;

    always_comb begin
        if (r_cfg == '0) begin
            active = CFG_BITS'(1);
        end else if (r_cfg > DEPTH_C) begin
            active = DEPTH_C;
        end else begin
            active = r_cfg;
        end
        pos_ext = CFG_BITS'(r_pos);
        ch      = (pos_ext < active) ? pos_ext : '0;
        ch_inc  = ch + CFG_BITS'(1);
        if (i_data.last_in_frame || (ch_inc >= active)) begin
            n_pos = '0;
        end else begin
            n_pos = ch_inc[CH_W-1:0];
        end
    end

    assign o_ready        = !i_full;
    assign o_push         = i_valid && !i_full;
    assign o_item.channel = ch;
    assign o_item.sample  = i_data.sample;
    assign o_item.last    = i_data.last_in_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
            r_pos <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (o_push) begin
                r_pos <= n_pos;
            end
        end
    end

endmodule

// ----- hdl/pcrs_queue.sv -----
// Short queue of classified samples between the front end and the statistics engine.
module pcrs_queue import pcrs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_work o_item,
    input  logic  i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_work            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/pcrs_div.sv -----
// Restoring divider that yields one quotient bit per cycle for the running mean.
module pcrs_div import pcrs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(SAMPLE_BITS + 1);
    localparam logic [STEP_W-1:0] STEPS = STEP_W'(SAMPLE_BITS);

    logic [COUNT_BITS-1:0]  r_rem;
    logic [SAMPLE_BITS-1:0] r_quo;
    logic [COUNT_BITS-1:0]  r_divisor;
    logic [STEP_W-1:0]      r_step;
    logic                   r_busy;
    logic                   r_done;
    logic [COUNT_BITS+1:0]  diff;

    assign diff = {1'b0, r_rem, r_quo[SAMPLE_BITS-1]} - {2'b00, r_divisor};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= i_req.dividend[SUM_BITS-1:SAMPLE_BITS];
            r_quo     <= i_req.dividend[SAMPLE_BITS-1:0];
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            if (!diff[COUNT_BITS+1]) begin
                r_rem <= diff[COUNT_BITS-1:0];
            end else begin
                r_rem <= {r_rem[COUNT_BITS-2:0], r_quo[SAMPLE_BITS-1]};
            end
            r_quo <= {r_quo[SAMPLE_BITS-2:0], !diff[COUNT_BITS+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEPS;
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- hdl/pcrs_back.sv -----
// Statistics engine: updates per-channel count, sum, minimum and maximum and forms results.
module pcrs_back import pcrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_work   i_q_item,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam int DEPTH = (MAX_CHANNELS < CFG_LIMIT) ? MAX_CHANNELS : CFG_LIMIT;
    localparam int CH_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_back_state r_state;
    t_back_state n_state;

    logic [COUNT_BITS-1:0]  r_cnt [DEPTH];
    logic [SUM_BITS-1:0]    r_sum [DEPTH];
    logic [SAMPLE_BITS-1:0] r_min [DEPTH];
    logic [SAMPLE_BITS-1:0] r_max [DEPTH];

    logic [COUNT_BITS-1:0]  r_res_cnt;
    logic [SAMPLE_BITS-1:0] r_res_min;
    logic [SAMPLE_BITS-1:0] r_res_max;
    logic [CH_OUT_BITS-1:0] r_res_ch;
    logic                   r_res_last;
    logic                   r_res_ovf;

    t_result r_out;
    logic    r_out_valid;

    logic [CH_W-1:0]        idx;
    logic [COUNT_BITS-1:0]  cur_cnt;
    logic [SUM_BITS-1:0]    cur_sum;
    logic [SAMPLE_BITS-1:0] cur_min;
    logic [SAMPLE_BITS-1:0] cur_max;
    logic                   first;
    logic                   full;
    logic [COUNT_BITS-1:0]  new_cnt;
    logic [SUM_BITS-1:0]    new_sum;
    logic [SAMPLE_BITS-1:0] new_min;
    logic [SAMPLE_BITS-1:0] new_max;
    logic                   take;
    logic                   load_out;
    t_div_req               div_req;
    t_div_rsp               div_rsp;

    always_comb begin
        idx     = i_q_item.channel[CH_W-1:0];
        cur_cnt = r_cnt[idx];
        cur_sum = r_sum[idx];
        cur_min = r_min[idx];
        cur_max = r_max[idx];
        first   = (cur_cnt == '0);
        full    = (cur_cnt == '1);
        if (first || (i_q_item.sample < cur_min)) begin
            new_min = i_q_item.sample;
        end else begin
            new_min = cur_min;
        end
        if (first || (i_q_item.sample > cur_max)) begin
            new_max = i_q_item.sample;
        end else begin
            new_max = cur_max;
        end
        new_cnt = full ? cur_cnt : cur_cnt + COUNT_BITS'(1);
        new_sum = full ? cur_sum : cur_sum + SUM_BITS'(i_q_item.sample);
    end

    always_comb begin
        n_state  = r_state;
        take     = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    take    = 1'b1;
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    n_state = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_q_pop          = take;
    assign div_req.start    = take;
    assign div_req.dividend = new_sum;
    assign div_req.divisor  = new_cnt;

    pcrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < DEPTH; c++) begin
                r_cnt[c] <= '0;
                r_sum[c] <= '0;
                r_min[c] <= '1;
                r_max[c] <= '0;
            end
        end else if (take) begin
            if (i_q_item.last) begin
                for (int c = 0; c < DEPTH; c++) begin
                    r_cnt[c] <= '0;
                    r_sum[c] <= '0;
                    r_min[c] <= '1;
                    r_max[c] <= '0;
                end
            end else begin
                r_cnt[idx] <= new_cnt;
                r_sum[idx] <= new_sum;
                r_min[idx] <= new_min;
                r_max[idx] <= new_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res_cnt  <= new_cnt;
            r_res_min  <= new_min;
            r_res_max  <= new_max;
            r_res_ch   <= i_q_item.channel[CH_OUT_BITS-1:0];
            r_res_last <= i_q_item.last;
            r_res_ovf  <= full;
        end
        if (load_out) begin
            r_out.channel      <= r_res_ch;
            r_out.mean         <= div_rsp.quotient;
            r_out.minimum      <= r_res_min;
            r_out.maximum      <= r_res_max;
            r_out.sample_count <= r_res_cnt;
            r_out.frame_done   <= r_res_last;
            r_out.overflow     <= r_res_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- hdl/per_channel_running_stats_top.sv -----
// Top level of the per-channel running mean, minimum, maximum and count block.
// For each sample the statistics engine reads and updates the channel's count, sum, minimum
// and maximum and starts the shared restoring divider; the divider forms the floor mean one
// quotient bit per cycle and reports completion; the engine then loads the output register,
// waiting while an earlier result there has not been taken. A two-entry queue after the front
// end accepts up to two further samples while one is in progress, and a result waiting in the
// output register does not block them.
// The channel count register may be written only while no transfer is in progress.
module per_channel_running_stats_top import pcrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_sample             i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output t_result             o_data,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

`include "per_channel_running_stats_top_macros.svh"

    logic  w_push;
    t_work w_push_item;
    logic  w_full;
    logic  w_q_valid;
    t_work w_q_item;
    logic  w_q_pop;

    pcrs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_push),
        .o_item     (w_push_item),
        .i_full     (w_full)
    );

    pcrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    pcrs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    `PCRS_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_q_pop, w_q_valid, "pop from empty queue")
    `PCRS_ASSERT_IMPL(a_ovf_full, i_clk, i_rst_n, o_valid && o_data.overflow, o_data.sample_count == '1, "overflow without full count")
    `PCRS_ASSERT_IMPL(a_mean_range, i_clk, i_rst_n, o_valid, (o_data.minimum <= o_data.mean) && (o_data.mean <= o_data.maximum), "mean outside minimum and maximum")
    `PCRS_ASSERT_NEXT(a_push_counted, i_clk, i_rst_n, w_push && !w_q_pop, w_q_valid, "pushed transfer not visible in queue")

endmodule
